[design/smbd_pkg.sv]
// shared constants, types and state encodings of the bounded splitmix64 draw
`default_nettype none

package smbd_pkg;

	localparam int unsigned BOUND_W = 32;
	localparam int unsigned STATE_W = 64;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [STATE_W-1:0] SEED_RESET   = 64'd1;
	localparam logic [STATE_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [STATE_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [STATE_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	localparam int unsigned MIX_SHIFT_A = 30;
	localparam int unsigned MIX_SHIFT_B = 27;
	localparam int unsigned MIX_SHIFT_C = 31;

	// one queued request, classified at the front
	typedef struct packed {
		logic               zero;
		logic [BOUND_W-1:0] bound;
	} req_entry_t;

	// head of the request queue as seen by the back part
	typedef struct packed {
		logic       valid;
		req_entry_t entry;
	} req_slot_t;

	typedef enum logic [2:0] {
		MIX_IDLE,
		MIX_XOR,
		MIX_MUL0,
		MIX_MUL1,
		MIX_MUL2,
		MIX_ACC,
		MIX_FIN
	} mix_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_THR,
		BK_DRAW,
		BK_MOD,
		BK_OUT
	} back_state_t;

endpackage

`default_nettype wire

[design/splitmix64_bounded_draw.sv]
// top level of the unbiased bounded draw from a splitmix64 generator
//
// usage
//  - s_tvalid/s_tready/s_tdata take one request: a bound, and each request
//    gives exactly one value on m_tvalid/m_tready/m_tdata, in request order
//  - the value is uniform in 0 .. bound-1; a zero bound gives 0 and leaves
//    the generator untouched
//  - cfg_valid/cfg_ready/cfg_data write the 64-bit seed, which reloads the
//    generator counter at once; write it only while no request is in flight
//  - a request whose first draw is kept takes two remainder passes in the
//    divider, one draw on the shared 32x32 multiplier, the queue and the
//    output register; every rejected draw adds one more draw; a zero bound
//    goes from the queue straight to the output register
//  - one request is worked at a time; the front queue keeps taking
//    requests up to its depth while the back end is busy
//  - when the receiver stalls the value is held in the output register and
//    the queue still fills; s_tready drops only once the queue is full
//  - reset clears the queue and the sequencers and loads the generator
//    counter with one
`default_nettype none

module splitmix64_bounded_draw import smbd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [BOUND_W-1:0] s_tdata,   // [31:0] bound
	// result channel
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [BOUND_W-1:0]      m_tdata,   // [31:0] value
	// seed write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [STATE_W-1:0] cfg_data   // [63:0] seed
);

	req_slot_t head;
	logic      pop;
	logic      seed_load;

	// seed writes are always taken, they only touch the counter
	assign cfg_ready = 1'b1;
	assign seed_load = cfg_valid && cfg_ready;

	smbd_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.head     (head),
		.pop      (pop)
	);

	smbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.seed      (cfg_data),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

[design/smbd_front.sv]
// request front end: accepts bounds, flags a zero bound and queues them
`default_nettype none

module smbd_front import smbd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [BOUND_W-1:0] s_tdata,
	output req_slot_t               head,
	input  wire logic               pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	req_entry_t       entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop_ok;
	req_entry_t       new_entry;

	assign s_tready = (count_q != CNT_FULL);
	assign push     = s_tvalid && s_tready;
	assign pop_ok   = pop && (count_q != '0);

	assign new_entry.zero  = (s_tdata == '0);
	assign new_entry.bound = s_tdata;

	assign head.valid = (count_q != '0);
	assign head.entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

endmodule

`default_nettype wire

[design/smbd_mix.sv]
// splitmix64 generator: counter plus mixer on one shared 32x32 multiplier
`default_nettype none

module smbd_mix import smbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seed_load,
	input  wire logic [STATE_W-1:0] seed,
	input  wire logic               start,
	output logic                    done,
	output logic [STATE_W-1:0]      draw
);

	mix_state_t         state_q;
	mix_state_t         state_d;
	logic               round_q;
	logic               done_q;
	logic [STATE_W-1:0] counter_q;
	logic [STATE_W-1:0] z_q;
	logic [STATE_W-1:0] acc_q;
	logic [STATE_W-1:0] prod_q;
	logic [STATE_W-1:0] draw_q;
	logic [STATE_W-1:0] mult;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [STATE_W-1:0] prod;

	assign mult = round_q ? MIX_MUL_B : MIX_MUL_A;
	assign prod = STATE_W'(mul_a) * STATE_W'(mul_b);
	assign done = done_q;
	assign draw = draw_q;

	// low 64 bits of z * mult from three partial products
	always_comb begin
		case (state_q)
			MIX_MUL1: begin
				mul_a = z_q[31:0];
				mul_b = mult[63:32];
			end
			MIX_MUL2: begin
				mul_a = z_q[63:32];
				mul_b = mult[31:0];
			end
			default: begin
				mul_a = z_q[31:0];
				mul_b = mult[31:0];
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MIX_IDLE: if (start) state_d = MIX_XOR;
			MIX_XOR:  state_d = MIX_MUL0;
			MIX_MUL0: state_d = MIX_MUL1;
			MIX_MUL1: state_d = MIX_MUL2;
			MIX_MUL2: state_d = MIX_ACC;
			MIX_ACC:  state_d = round_q ? MIX_FIN : MIX_XOR;
			MIX_FIN:  state_d = MIX_IDLE;
			default:  state_d = MIX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MIX_IDLE;
			round_q   <= 1'b0;
			done_q    <= 1'b0;
			counter_q <= SEED_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				MIX_IDLE: begin
					if (start) begin
						counter_q <= counter_q + GOLDEN_GAMMA;
						round_q   <= 1'b0;
					end
				end
				MIX_ACC:  round_q <= 1'b1;
				MIX_FIN:  done_q  <= 1'b1;
				default:  round_q <= round_q;
			endcase
			if (seed_load) begin
				counter_q <= seed;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MIX_XOR: begin
				z_q <= round_q ? (acc_q ^ (acc_q >> MIX_SHIFT_B))
				               : (counter_q ^ (counter_q >> MIX_SHIFT_A));
			end
			MIX_MUL0: prod_q <= prod;
			MIX_MUL1: begin
				prod_q <= prod;
				acc_q  <= prod_q;
			end
			MIX_MUL2: begin
				prod_q <= prod;
				acc_q  <= acc_q + {prod_q[31:0], 32'd0};
			end
			MIX_ACC:  acc_q  <= acc_q + {prod_q[31:0], 32'd0};
			MIX_FIN:  draw_q <= acc_q ^ (acc_q >> MIX_SHIFT_C);
			default:  acc_q  <= acc_q;
		endcase
	end

endmodule

`default_nettype wire

[design/smbd_div.sv]
// 64 by 32 bit remainder unit, restoring, two quotient bits a cycle
`default_nettype none

module smbd_div import smbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [STATE_W-1:0] dividend,
	input  wire logic [BOUND_W-1:0] divisor,
	output logic                    done,
	output logic [BOUND_W-1:0]      rem
);

	localparam int unsigned STEPS = STATE_W / 2;
	localparam int unsigned CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STATE_W-1:0] num_q;
	logic [BOUND_W-1:0] rem_q;
	logic [BOUND_W-1:0] div_q;
	logic [BOUND_W-1:0] rem_one;
	logic [BOUND_W-1:0] rem_two;

	function automatic logic [BOUND_W-1:0] rem_step(
		input logic [BOUND_W-1:0] r,
		input logic               b,
		input logic [BOUND_W-1:0] d
	);
		logic [BOUND_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[BOUND_W-1:0];
	endfunction

	assign rem_one = rem_step(rem_q, num_q[STATE_W-1], div_q);
	assign rem_two = rem_step(rem_one, num_q[STATE_W-2], div_q);
	assign done    = done_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[STATE_W-3:0], 2'b00};
			rem_q <= rem_two;
		end
	end

endmodule

`default_nettype wire

[design/smbd_back.sv]
// draw sequencer: rejection threshold, draws, reduction and output register
`default_nettype none

module smbd_back import smbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seed_load,
	input  wire logic [STATE_W-1:0] seed,
	input  wire req_slot_t          head,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [BOUND_W-1:0]      m_tdata
);

	back_state_t        state_q;
	back_state_t        state_d;
	logic [BOUND_W-1:0] bound_q;
	logic [BOUND_W-1:0] thr_q;
	logic [BOUND_W-1:0] value_q;
	logic               mix_start;
	logic               mix_done;
	logic [STATE_W-1:0] mix_draw;
	logic               div_start;
	logic               div_done;
	logic [STATE_W-1:0] div_dividend;
	logic [BOUND_W-1:0] div_divisor;
	logic [BOUND_W-1:0] div_rem;
	logic               reject;

	assign reject   = (mix_draw < {{(STATE_W-BOUND_W){1'b0}}, thr_q});
	assign m_tvalid = (state_q == BK_OUT);
	assign m_tdata  = value_q;

	// threshold is (2^64 - bound) mod bound, remainder taken of 0 - bound
	assign div_divisor  = (state_q == BK_IDLE) ? head.entry.bound : bound_q;
	assign div_dividend = (state_q == BK_IDLE)
		? (STATE_W'(0) - {{(STATE_W-BOUND_W){1'b0}}, head.entry.bound})
		: mix_draw;

	smbd_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.seed      (seed),
		.start     (mix_start),
		.done      (mix_done),
		.draw      (mix_draw)
	);

	smbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mix_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.entry.zero) begin
						state_d = BK_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = BK_THR;
					end
				end
			end
			BK_THR: begin
				if (div_done) begin
					mix_start = 1'b1;
					state_d   = BK_DRAW;
				end
			end
			BK_DRAW: begin
				if (mix_done) begin
					if (reject) begin
						mix_start = 1'b1;
					end else begin
						div_start = 1'b1;
						state_d   = BK_MOD;
					end
				end
			end
			BK_MOD: if (div_done) state_d = BK_OUT;
			BK_OUT: if (m_tready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && head.valid) begin
			bound_q <= head.entry.bound;
			value_q <= '0;
		end
		if (state_q == BK_THR && div_done) begin
			thr_q <= div_rem;
		end
		if (state_q == BK_MOD && div_done) begin
			value_q <= div_rem;
		end
	end

endmodule

`default_nettype wire

[design/smbd_checker.sv]
// port-level checker of the bounded draw, bound to the top level
`default_nettype none

module smbd_checker import smbd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [BOUND_W-1:0] m_tdata
);

	localparam int unsigned OUT_W = $clog2(QUEUE_DEPTH + 2);
	localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(QUEUE_DEPTH + 1);

	logic [OUT_W-1:0] pending_q;
	logic             req_in;
	logic             res_out;

	assign req_in  = s_tvalid && s_tready;
	assign res_out = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({req_in, res_out})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// a stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result without a request behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != '0)
		else $error("result without a pending request");

	// queue plus the request in work bound what can be outstanding
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OUT_MAX)
		else $error("more requests outstanding than the block holds");

	// at capacity the request side must be closed
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == OUT_MAX |-> !s_tready)
		else $error("request taken with no room left");

endmodule

bind splitmix64_bounded_draw smbd_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_smbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire
